/* design/rtca_pkg.sv */
package rtca_pkg;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] ADDR_COUNT    = 3'd0;
    localparam logic [2:0] ADDR_PERIODIC = 3'd1;
    localparam logic [2:0] ADDR_ALARM    = 3'd2;
    localparam logic [2:0] ADDR_DISABLE  = 3'd3;
    localparam logic [2:0] ADDR_COUNT_MS = 3'd4;
    localparam logic [2:0] ADDR_COMPARE  = 3'd5;

    localparam logic [31:0] MS_PER_SEC = 32'd1000;
    localparam logic [31:0] ROUND_HALF = 32'd500;
    localparam logic [31:0] MS_MAX     = 32'd4194303;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  addr;
        logic [31:0] data;
        logic [31:0] ticks;
        logic [31:0] data_ms;
    } t_req;

endpackage

/* design/rtca_req_stage.sv */
module rtca_req_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_kind,
    input  logic [2:0]     i_reg_addr,
    input  logic [31:0]    i_write_data,
    input  logic           i_adv,
    output logic           o_req_valid,
    output rtca_pkg::t_req o_req
);

    localparam logic [31:0] DIV1000_MAGIC = 32'h10624DD3;

    logic           r_valid;
    rtca_pkg::t_req r_req;
    rtca_pkg::t_req n_req;
    logic [21:0]    w_ms_sat;
    logic [31:0]    w_scaled;
    logic [63:0]    w_prod;

    assign o_in_stall  = r_valid && !i_adv;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;

    always_comb begin
        w_ms_sat = (i_write_data > rtca_pkg::MS_MAX) ? rtca_pkg::MS_MAX[21:0]
                                                     : i_write_data[21:0];
        w_scaled = {w_ms_sat, 10'b0} + rtca_pkg::ROUND_HALF;
        w_prod   = 64'(w_scaled) * 64'(DIV1000_MAGIC);

        n_req.kind    = i_kind;
        n_req.addr    = i_reg_addr;
        n_req.data    = i_write_data;
        n_req.ticks   = {6'b0, w_prod[63:38]};
        n_req.data_ms = (i_write_data << 10) - (i_write_data << 5)
                      + (i_write_data << 3) + rtca_pkg::ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_req <= n_req;
        end
    end

endmodule

/* design/rtca_core.sv */
module rtca_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  rtca_pkg::t_req i_req,
    output logic           o_adv,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [31:0]    o_read_data,
    output logic           o_irq_pulse
);

    logic        r_out_valid;
    logic [31:0] r_out_rdata;
    logic        r_out_irq;
    logic [31:0] r_count;
    logic [31:0] r_count_ms;
    logic [31:0] r_compare;
    logic [31:0] r_period;
    logic        r_alarm_en;
    logic [31:0] n_count;
    logic [31:0] n_count_ms;
    logic [31:0] n_compare;
    logic [31:0] n_period;
    logic        n_alarm_en;
    logic [31:0] n_rdata;
    logic        n_irq;
    logic        w_fire;

    assign o_adv       = !r_out_valid || !i_out_stall;
    assign w_fire      = i_req_valid && o_adv;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_rdata;
    assign o_irq_pulse = r_out_irq;

    always_comb begin
        n_count    = r_count;
        n_count_ms = r_count_ms;
        n_compare  = r_compare;
        n_period   = r_period;
        n_alarm_en = r_alarm_en;
        n_rdata    = 32'd0;
        n_irq      = 1'b0;
        case (i_req.kind)
            rtca_pkg::KIND_TICK: begin
                n_count    = r_count + 32'd1;
                n_count_ms = r_count_ms + rtca_pkg::MS_PER_SEC;
                if (r_alarm_en && (n_count == r_compare)) begin
                    n_irq = 1'b1;
                    if (r_period != 32'd0) begin
                        n_compare = r_compare + r_period;
                    end else begin
                        n_alarm_en = 1'b0;
                    end
                end
            end
            rtca_pkg::KIND_WRITE: begin
                case (i_req.addr)
                    rtca_pkg::ADDR_COUNT: begin
                        n_count    = i_req.data;
                        n_count_ms = i_req.data_ms;
                    end
                    rtca_pkg::ADDR_PERIODIC: begin
                        if (i_req.ticks != 32'd0) begin
                            n_period   = i_req.ticks;
                            n_compare  = r_count + i_req.ticks;
                            n_alarm_en = 1'b1;
                        end
                    end
                    rtca_pkg::ADDR_ALARM: begin
                        n_compare  = i_req.ticks;
                        n_period   = 32'd0;
                        n_alarm_en = 1'b1;
                    end
                    rtca_pkg::ADDR_DISABLE: begin
                        n_period   = 32'd0;
                        n_alarm_en = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            rtca_pkg::KIND_READ: begin
                case (i_req.addr)
                    rtca_pkg::ADDR_COUNT:    n_rdata = r_count;
                    rtca_pkg::ADDR_COUNT_MS: n_rdata = {10'b0, r_count_ms[31:10]};
                    rtca_pkg::ADDR_COMPARE:  n_rdata = r_compare;
                    default:                 n_rdata = 32'd0;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= 32'd0;
            r_count_ms  <= rtca_pkg::ROUND_HALF;
            r_compare   <= 32'd0;
            r_period    <= 32'd0;
            r_alarm_en  <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
            r_count     <= n_count;
            r_count_ms  <= n_count_ms;
            r_compare   <= n_compare;
            r_period    <= n_period;
            r_alarm_en  <= n_alarm_en;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire) begin
            r_out_rdata <= n_rdata;
            r_out_irq   <= n_irq;
        end
    end

    a_irq_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_req.kind != rtca_pkg::KIND_TICK)) |=> !r_out_irq)
        else $error("irq raised by a non-tick request");

    a_rdata_zero_off_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_req.kind != rtca_pkg::KIND_READ)) |=> (r_out_rdata == 32'd0))
        else $error("read data nonzero on a non-read request");

    a_oneshot_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_irq && (r_period == 32'd0)) |=> !r_alarm_en)
        else $error("one-shot alarm still armed after match");

    a_ms_shadow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_ms == 32'(r_count * rtca_pkg::MS_PER_SEC + rtca_pkg::ROUND_HALF))
        else $error("millisecond shadow out of step with counter");

endmodule

/* design/rtc_compare_alarm_timer.sv */
// Real-time counter with one compare alarm, driven by a request stream of
// 1024 Hz ticks, register writes and register reads. Every request yields one
// response (read data, and an irq pulse on the tick that hits the compare).
// Throughput is one request per clock while the response is not stalled; each
// request passes the request register (which also does the ms-to-tick conversion
// with one multiply) and then the response register behind the counter state update.
module rtc_compare_alarm_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_reg_addr,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic        o_irq_pulse
);

    logic           w_adv;
    logic           w_req_valid;
    rtca_pkg::t_req w_req;

    rtca_req_stage u_req_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_adv        (w_adv),
        .o_req_valid  (w_req_valid),
        .o_req        (w_req)
    );

    rtca_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data),
        .o_irq_pulse (o_irq_pulse)
    );

endmodule
